@@ src/pamt_pkg.sv @@
// Shared types, widths and codes for the pending-ack message table.
// Used by the entry RAM, the match unit and the top-level sequencer.
// No dependencies.
package pamt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ID_W        = 24;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 24;
    localparam int MARK_W      = 5;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [ID_W-1:0]   id_t;
    typedef logic [MARK_W-1:0] mark_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam mark_t MARK_MAX = {MARK_W{1'b1}};

    localparam cfg_idx_t REG_DEFAULT_ID = cfg_idx_t'(0);
    localparam cfg_idx_t REG_UNKNOWN_DT = cfg_idx_t'(1);

    typedef enum logic [1:0] {
        MODE_ADD      = 2'd0,
        MODE_ACK      = 2'd1,
        MODE_CALL_END = 2'd2,
        MODE_CLEAR    = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ACT_ADDED    = 3'd0,
        ACT_REJECTED = 3'd1,
        ACT_FULL     = 3'd2,
        ACT_ACK_DONE = 3'd3,
        ACT_LOG      = 3'd4,
        ACT_RETX     = 3'd5,
        ACT_DISCARD  = 3'd6,
        ACT_NONE     = 3'd7
    } action_t;

    typedef struct packed {
        logic       acked;
        id_t        dst;
        id_t        src;
        logic [1:0] call_type;
        logic [3:0] data_type;
        logic [7:0] msg;
    } entry_t;

    typedef struct packed {
        id_t        dst;
        id_t        src;
        logic [1:0] call_type;
        logic [3:0] data_type;
    } key_t;

    typedef struct packed {
        logic ack_hit;
        logic call_hit;
        logic own_id;
    } match_t;

    typedef struct packed {
        action_t    action;
        id_t        dst;
        id_t        src;
        logic [1:0] call_type;
        logic [3:0] data_type;
        logic [7:0] msg;
        logic       timeslot;
        logic [7:0] repeater;
        mark_t      marked;
        logic       last;
    } res_t;

    // Map a position counted from the newest entry onto a RAM address.
    function automatic idx_t phys_addr(idx_t head, idx_t lidx);
        logic [IDX_W:0] sum;
        sum = {1'b0, head} + {1'b0, lidx};
        if (sum >= (IDX_W+1)'(TABLE_DEPTH)) begin
            sum = sum - (IDX_W+1)'(TABLE_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

@@ src/pamt_entry_ram.sv @@
// Entry storage of the pending-ack table: one write port, one registered read port.
// Depends on pamt_pkg for the entry layout and depth.
module pamt_entry_ram import pamt_pkg::*; (
    input  logic   aclk,
    input  logic   we,
    input  idx_t   waddr,
    input  entry_t wdata,
    input  logic   re,
    input  idx_t   raddr,
    output entry_t rdata
);

    entry_t mem [TABLE_DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/pamt_match.sv @@
// Shared compare unit: checks one table entry against the ack or call key.
// Depends on pamt_pkg for entry, key and match types.
module pamt_match import pamt_pkg::*; (
    input  entry_t entry,
    input  key_t   key,
    input  id_t    def_id,
    output match_t hit
);

    logic same_dir;
    logic swap_dir;
    logic ct_eq;

    assign ct_eq    = entry.call_type == key.call_type;
    assign same_dir = (entry.dst == key.dst) && (entry.src == key.src);
    assign swap_dir = (entry.dst == key.src) && (entry.src == key.dst);

    assign hit.ack_hit  = swap_dir && ct_eq && (entry.data_type == key.data_type);
    assign hit.call_hit = ct_eq && (same_dir || swap_dir);
    assign hit.own_id   = (entry.dst == def_id) || (entry.src == def_id);

endmodule

@@ src/pending_ack_message_table.sv @@
// Pending-ack message table: up to 16 entries in a ring held in one RAM, walked by a
// sequencer through one compare unit. Add, full, clear and rejected adds go from accept
// straight to the finish state; ack and call end scan one entry per cycle while no removal
// waits on a stalled result channel, then finish. s_ready is low while an item is worked;
// the last result of an item sits in the output register while the next item may already
// be accepted. Call end emits one beat per removed entry (one none beat if none match),
// newest first, with m_last on the final beat. Config writes are always ready.
module pending_ack_message_table import pamt_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,

    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  cfg_idx_t         cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_mode,
    input  logic [23:0]      s_dst_id,
    input  logic [23:0]      s_src_id,
    input  logic [1:0]       s_call_type,
    input  logic [3:0]       s_data_type,
    input  logic [7:0]       s_msg_handle,
    input  logic             s_msg_present,
    input  logic             s_timeslot,
    input  logic [7:0]       s_repeater_index,

    output logic             m_valid,
    input  logic             m_ready,
    output logic [2:0]       m_action,
    output logic [23:0]      m_out_dst_id,
    output logic [23:0]      m_out_src_id,
    output logic [1:0]       m_out_call_type,
    output logic [3:0]       m_out_data_type,
    output logic [7:0]       m_out_msg_handle,
    output logic             m_out_timeslot,
    output logic [7:0]       m_out_repeater_index,
    output logic [4:0]       m_marked_count,
    output logic             m_last
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t  state_reg, state_next;
    mode_t   mode_reg, mode_next;
    key_t    key_reg, key_next;
    logic    ts_reg, ts_next;
    logic [7:0] rep_reg, rep_next;
    action_t fin_action_reg, fin_action_next;

    cnt_t    count_reg, count_next;
    idx_t    head_reg, head_next;
    cnt_t    rd_cnt_reg, rd_cnt_next;
    cnt_t    w_reg, w_next;
    logic    ev_valid_reg, ev_valid_next;
    idx_t    ev_phys_reg, ev_phys_next;
    mark_t   mark_reg, mark_next;

    res_t    hold_reg, hold_next;
    logic    hold_valid_reg, hold_valid_next;
    res_t    out_reg, out_next;
    logic    out_valid_reg, out_valid_next;
    logic    out_load;

    id_t        def_id_reg, def_id_next;
    logic [3:0] unk_dt_reg, unk_dt_next;

    logic    ram_we;
    idx_t    ram_waddr;
    entry_t  ram_wdata;
    logic    ram_re;
    idx_t    ram_raddr;
    entry_t  ram_rdata;
    match_t  hit;

    logic    out_free;
    logic    stall;
    logic    reject;
    idx_t    head_dec;
    res_t    removed;

    pamt_entry_ram u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pamt_match u_match (
        .entry  (ram_rdata),
        .key    (key_reg),
        .def_id (def_id_reg),
        .hit    (hit)
    );

    assign cfg_ready = 1'b1;
    assign s_ready   = state_reg == ST_IDLE;
    assign out_free  = !out_valid_reg || m_ready;

    assign reject   = !s_msg_present || (s_data_type == unk_dt_reg) ||
                      (s_dst_id == '0) || (s_src_id == '0);
    assign head_dec = (head_reg == '0) ? idx_t'(TABLE_DEPTH - 1) : head_reg - idx_t'(1);

    // Result beat for an entry removed at call end.
    always_comb begin
        removed           = '0;
        removed.action    = ram_rdata.acked ? ACT_LOG : (hit.own_id ? ACT_DISCARD : ACT_RETX);
        removed.dst       = ram_rdata.dst;
        removed.src       = ram_rdata.src;
        removed.call_type = ram_rdata.call_type;
        removed.data_type = ram_rdata.data_type;
        removed.msg       = ram_rdata.msg;
        removed.timeslot  = ts_reg;
        removed.repeater  = rep_reg;
    end

    assign stall = ev_valid_reg && (mode_reg == MODE_CALL_END) && hit.call_hit &&
                   hold_valid_reg && !out_free;

    always_comb begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        key_next        = key_reg;
        ts_next         = ts_reg;
        rep_next        = rep_reg;
        fin_action_next = fin_action_reg;
        count_next      = count_reg;
        head_next       = head_reg;
        rd_cnt_next     = rd_cnt_reg;
        w_next          = w_reg;
        ev_valid_next   = ev_valid_reg;
        ev_phys_next    = ev_phys_reg;
        mark_next       = mark_reg;
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        out_load        = 1'b0;
        def_id_next     = def_id_reg;
        unk_dt_next     = unk_dt_reg;

        ram_we    = 1'b0;
        ram_waddr = phys_addr(head_reg, w_reg[IDX_W-1:0]);
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = phys_addr(head_reg, rd_cnt_reg[IDX_W-1:0]);

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid) begin
            case (cfg_index)
                REG_DEFAULT_ID: def_id_next = cfg_data[ID_W-1:0];
                REG_UNKNOWN_DT: unk_dt_next = cfg_data[3:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    mode_next          = mode_t'(s_mode);
                    key_next.dst       = s_dst_id;
                    key_next.src       = s_src_id;
                    key_next.call_type = s_call_type;
                    key_next.data_type = s_data_type;
                    ts_next            = s_timeslot;
                    rep_next           = s_repeater_index;
                    rd_cnt_next        = '0;
                    w_next             = '0;
                    ev_valid_next      = 1'b0;
                    mark_next          = '0;
                    hold_valid_next    = 1'b0;
                    case (mode_t'(s_mode))
                        MODE_ADD: begin
                            state_next = ST_FINISH;
                            if (reject) begin
                                fin_action_next = ACT_REJECTED;
                            end else if (count_reg == cnt_t'(TABLE_DEPTH)) begin
                                fin_action_next = ACT_FULL;
                            end else begin
                                fin_action_next     = ACT_ADDED;
                                ram_we              = 1'b1;
                                ram_waddr           = head_dec;
                                ram_wdata.acked     = 1'b0;
                                ram_wdata.dst       = s_dst_id;
                                ram_wdata.src       = s_src_id;
                                ram_wdata.call_type = s_call_type;
                                ram_wdata.data_type = s_data_type;
                                ram_wdata.msg       = s_msg_handle;
                                head_next           = head_dec;
                                count_next          = count_reg + cnt_t'(1);
                            end
                        end
                        MODE_ACK, MODE_CALL_END: begin
                            state_next = ST_SCAN;
                        end
                        MODE_CLEAR: begin
                            count_next      = '0;
                            fin_action_next = ACT_NONE;
                            state_next      = ST_FINISH;
                        end
                        default: ;
                    endcase
                end
            end

            ST_SCAN: begin
                if (!stall) begin
                    if (ev_valid_reg) begin
                        if (mode_reg == MODE_ACK) begin
                            if (hit.ack_hit) begin
                                ram_we          = 1'b1;
                                ram_waddr       = ev_phys_reg;
                                ram_wdata.acked = 1'b1;
                                if (!ram_rdata.acked && mark_reg != MARK_MAX) begin
                                    mark_next = mark_reg + mark_t'(1);
                                end
                            end
                        end else if (hit.call_hit) begin
                            // Push the previous removal out, keep this one back for m_last.
                            if (hold_valid_reg) begin
                                out_next       = hold_reg;
                                out_valid_next = 1'b1;
                                out_load       = 1'b1;
                            end
                            hold_next       = removed;
                            hold_valid_next = 1'b1;
                        end else begin
                            // Compact kept entries toward the newest end.
                            ram_we = 1'b1;
                            w_next = w_reg + cnt_t'(1);
                        end
                    end
                    if (rd_cnt_reg < count_reg) begin
                        ram_re        = 1'b1;
                        ev_valid_next = 1'b1;
                        ev_phys_next  = ram_raddr;
                        rd_cnt_next   = rd_cnt_reg + cnt_t'(1);
                    end else begin
                        ev_valid_next = 1'b0;
                        if (!ev_valid_reg) begin
                            state_next = ST_FINISH;
                            if (mode_reg == MODE_CALL_END) begin
                                count_next = w_reg;
                            end
                        end
                    end
                end
            end

            ST_FINISH: begin
                if (out_free) begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    out_next       = '0;
                    out_next.last  = 1'b1;
                    if (mode_reg == MODE_CALL_END) begin
                        if (hold_valid_reg) begin
                            out_next      = hold_reg;
                            out_next.last = 1'b1;
                        end else begin
                            out_next.action = ACT_NONE;
                        end
                    end else if (mode_reg == MODE_ACK) begin
                        out_next.action = (mark_reg != '0) ? ACT_ACK_DONE : ACT_NONE;
                        out_next.marked = mark_reg;
                    end else begin
                        out_next.action = fin_action_reg;
                    end
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        mode_next_hold: begin
            mode_reg       <= mode_next;
            key_reg        <= key_next;
            ts_reg         <= ts_next;
            rep_reg        <= rep_next;
            fin_action_reg <= fin_action_next;
            ev_phys_reg    <= ev_phys_next;
            hold_reg       <= hold_next;
            out_reg        <= out_next;
        end
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            head_reg       <= '0;
            rd_cnt_reg     <= '0;
            w_reg          <= '0;
            ev_valid_reg   <= 1'b0;
            mark_reg       <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            def_id_reg     <= '0;
            unk_dt_reg     <= '0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            head_reg       <= head_next;
            rd_cnt_reg     <= rd_cnt_next;
            w_reg          <= w_next;
            ev_valid_reg   <= ev_valid_next;
            mark_reg       <= mark_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
            def_id_reg     <= def_id_next;
            unk_dt_reg     <= unk_dt_next;
        end
    end

    assign m_valid              = out_valid_reg;
    assign m_action             = out_reg.action;
    assign m_out_dst_id         = out_reg.dst;
    assign m_out_src_id         = out_reg.src;
    assign m_out_call_type      = out_reg.call_type;
    assign m_out_data_type      = out_reg.data_type;
    assign m_out_msg_handle     = out_reg.msg;
    assign m_out_timeslot       = out_reg.timeslot;
    assign m_out_repeater_index = out_reg.repeater;
    assign m_marked_count       = out_reg.marked;
    assign m_last               = out_reg.last;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= cnt_t'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_idle_no_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !hold_valid_reg)
        else $error("held removal left behind after item end");

    a_compact_behind_read: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> w_reg <= rd_cnt_reg)
        else $error("compaction pointer passed read pointer");

    a_scan_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && out_load) |-> !out_next.last)
        else $error("last beat issued before scan end");

endmodule

@@ sim/pending_table_checker.sv @@
// Checker for the pending-ack message table: predicts result beats from
// accepted commands and register writes, compares every result beat.
// Depends on pamt_pkg for the entry, result and code types.
module pending_table_checker import pamt_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  cfg_idx_t              cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [1:0]            s_mode,
    input  logic [23:0]           s_dst_id,
    input  logic [23:0]           s_src_id,
    input  logic [1:0]            s_call_type,
    input  logic [3:0]            s_data_type,
    input  logic [7:0]            s_msg_handle,
    input  logic                  s_msg_present,
    input  logic                  s_timeslot,
    input  logic [7:0]            s_repeater_index,

    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [2:0]            m_action,
    input  logic [23:0]           m_out_dst_id,
    input  logic [23:0]           m_out_src_id,
    input  logic [1:0]            m_out_call_type,
    input  logic [3:0]            m_out_data_type,
    input  logic [7:0]            m_out_msg_handle,
    input  logic                  m_out_timeslot,
    input  logic [7:0]            m_out_repeater_index,
    input  logic [4:0]            m_marked_count,
    input  logic                  m_last,

    output int                    fail_count,
    output int                    results_pending,
    output int                    commands_seen,
    output int                    beats_seen,
    output int                    entries_removed,
    output int                    full_hits
);

    id_t        own_id;
    logic [3:0] unknown_dt;

    // slot 0 holds the newest entry; live entries are always packed from slot 0
    logic       slot_live [TABLE_DEPTH];
    entry_t     slot      [TABLE_DEPTH];

    res_t       expected_beats [$];

    task automatic report_mismatch(string msg);
        $display("[%0t] MISMATCH on beat %0d: %s", $time, beats_seen, msg);
        fail_count++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
        end
    endtask

    function automatic void apply_command(mode_t mode, id_t dst, id_t src,
                                          logic [1:0] ct, logic [3:0] dt,
                                          logic [7:0] msg, logic present,
                                          logic ts, logic [7:0] rep);
        res_t r;
        res_t held;
        bit   have_held;
        int   n_live;
        int   hits;
        int   i;
        int   k;
        r = '0;
        r.last = 1'b1;
        have_held = 1'b0;
        case (mode)
            MODE_ADD: begin
                n_live = 0;
                for (i = 0; i < TABLE_DEPTH; i++) begin
                    if (slot_live[i]) n_live++;
                end
                if (!present || dt == unknown_dt || dst == '0 || src == '0) begin
                    r.action = ACT_REJECTED;
                end else if (n_live >= TABLE_DEPTH) begin
                    r.action = ACT_FULL;
                end else begin
                    for (i = TABLE_DEPTH - 1; i > 0; i--) begin
                        slot_live[i] = slot_live[i-1];
                        slot[i]      = slot[i-1];
                    end
                    slot_live[0]       = 1'b1;
                    slot[0].acked      = 1'b0;
                    slot[0].dst        = dst;
                    slot[0].src        = src;
                    slot[0].call_type  = ct;
                    slot[0].data_type  = dt;
                    slot[0].msg        = msg;
                    r.action = ACT_ADDED;
                end
                expected_beats.push_back(r);
            end
            MODE_ACK: begin
                hits = 0;
                for (i = 0; i < TABLE_DEPTH; i++) begin
                    if (slot_live[i] && slot[i].dst == src && slot[i].src == dst &&
                        slot[i].call_type == ct && slot[i].data_type == dt) begin
                        if (!slot[i].acked && hits < 31) hits++;
                        slot[i].acked = 1'b1;
                    end
                end
                r.action = (hits != 0) ? ACT_ACK_DONE : ACT_NONE;
                r.marked = mark_t'(hits);
                expected_beats.push_back(r);
            end
            MODE_CALL_END: begin
                i = 0;
                while (i < TABLE_DEPTH) begin
                    if (slot_live[i] && slot[i].call_type == ct &&
                        ((slot[i].dst == src && slot[i].src == dst) ||
                         (slot[i].dst == dst && slot[i].src == src))) begin
                        // hold each beat back one step so the final one can carry last
                        if (have_held) expected_beats.push_back(held);
                        held = '0;
                        if (slot[i].acked) begin
                            held.action = ACT_LOG;
                        end else if (slot[i].dst == own_id || slot[i].src == own_id) begin
                            held.action = ACT_DISCARD;
                        end else begin
                            held.action = ACT_RETX;
                        end
                        held.dst       = slot[i].dst;
                        held.src       = slot[i].src;
                        held.call_type = slot[i].call_type;
                        held.data_type = slot[i].data_type;
                        held.msg       = slot[i].msg;
                        held.timeslot  = ts;
                        held.repeater  = rep;
                        have_held = 1'b1;
                        for (k = i; k + 1 < TABLE_DEPTH; k++) begin
                            slot_live[k] = slot_live[k+1];
                            slot[k]      = slot[k+1];
                        end
                        slot_live[TABLE_DEPTH-1] = 1'b0;
                    end else begin
                        i++;
                    end
                end
                if (have_held) begin
                    held.last = 1'b1;
                    expected_beats.push_back(held);
                end else begin
                    r.action = ACT_NONE;
                    expected_beats.push_back(r);
                end
            end
            default: begin
                for (i = 0; i < TABLE_DEPTH; i++) slot_live[i] = 1'b0;
                r.action = ACT_NONE;
                expected_beats.push_back(r);
            end
        endcase
    endfunction

    always @(posedge aclk) begin
        res_t want;
        if (!aresetn) begin
            own_id     = '0;
            unknown_dt = '0;
            for (int i = 0; i < TABLE_DEPTH; i++) slot_live[i] = 1'b0;
            expected_beats.delete();
            fail_count      = 0;
            commands_seen   = 0;
            beats_seen      = 0;
            entries_removed = 0;
            full_hits       = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_DEFAULT_ID) begin
                    own_id = cfg_data;
                end else if (cfg_index == REG_UNKNOWN_DT) begin
                    unknown_dt = cfg_data[3:0];
                end
            end
            if (m_valid && m_ready) begin
                beats_seen++;
                if (expected_beats.size() == 0) begin
                    report_mismatch("result beat with no command waiting on it");
                end else begin
                    want = expected_beats.pop_front();
                    check_field("action",         32'(m_action),             32'(want.action));
                    check_field("out_dst_id",     32'(m_out_dst_id),         32'(want.dst));
                    check_field("out_src_id",     32'(m_out_src_id),         32'(want.src));
                    check_field("out_call_type",  32'(m_out_call_type),      32'(want.call_type));
                    check_field("out_data_type",  32'(m_out_data_type),      32'(want.data_type));
                    check_field("out_msg_handle", 32'(m_out_msg_handle),     32'(want.msg));
                    check_field("out_timeslot",   32'(m_out_timeslot),       32'(want.timeslot));
                    check_field("out_repeater",   32'(m_out_repeater_index), 32'(want.repeater));
                    check_field("marked_count",   32'(m_marked_count),       32'(want.marked));
                    check_field("last",           32'(m_last),               32'(want.last));
                    if (want.action == ACT_LOG || want.action == ACT_RETX ||
                        want.action == ACT_DISCARD) entries_removed++;
                    if (want.action == ACT_FULL) full_hits++;
                end
            end
            if (s_valid && s_ready) begin
                commands_seen++;
                apply_command(mode_t'(s_mode), s_dst_id, s_src_id, s_call_type, s_data_type,
                              s_msg_handle, s_msg_present, s_timeslot, s_repeater_index);
            end
        end
        results_pending = expected_beats.size();
    end

endmodule

@@ sim/tb.sv @@
// Top of the pending-ack message table bench: clock, reset, register writes,
// command stimulus, result back-pressure and the verdict.
// Depends on pamt_pkg, pending_ack_message_table and pending_table_checker.
module tb;
    import pamt_pkg::*;

    localparam int CYCLE_LIMIT     = 4000000;
    localparam int N_PHASES        = 12;
    localparam int ITEMS_PER_PHASE = 30;
    localparam int POOL_N          = 4;
    localparam int DRAIN_CYCLES    = 2 * TABLE_DEPTH;
    localparam id_t OWN_ID_DIRECTED = 24'h00A5A5;

    logic                  aclk = 1'b0;
    logic                  aresetn;

    logic                  cfg_valid;
    logic                  cfg_ready;
    cfg_idx_t              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic                  s_valid;
    logic                  s_ready;
    logic [1:0]            s_mode;
    logic [23:0]           s_dst_id;
    logic [23:0]           s_src_id;
    logic [1:0]            s_call_type;
    logic [3:0]            s_data_type;
    logic [7:0]            s_msg_handle;
    logic                  s_msg_present;
    logic                  s_timeslot;
    logic [7:0]            s_repeater_index;

    logic                  m_valid;
    logic                  m_ready;
    logic [2:0]            m_action;
    logic [23:0]           m_out_dst_id;
    logic [23:0]           m_out_src_id;
    logic [1:0]            m_out_call_type;
    logic [3:0]            m_out_data_type;
    logic [7:0]            m_out_msg_handle;
    logic                  m_out_timeslot;
    logic [7:0]            m_out_repeater_index;
    logic [4:0]            m_marked_count;
    logic                  m_last;

    int fail_count;
    int results_pending;
    int commands_seen;
    int beats_seen;
    int entries_removed;
    int full_hits;

    int         cycle_count = 0;
    bit         calm = 1'b0;
    id_t        id_pool [POOL_N];
    logic [1:0] ct_pool [2];
    logic [3:0] dt_pool [2];
    id_t        own_id;
    logic [3:0] unknown_code;

    pending_ack_message_table i_dut (.*);

    pending_table_checker i_checker (.*);

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run stopped at the cycle limit with %0d beats still owed",
                     results_pending);
            $display("Test completed with failures");
            $finish;
        end
    end

    // mostly no gap, sometimes a short one, rarely a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // result side back-pressure
    initial begin
        int run;
        int gap;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            run = $urandom_range(1, 24);
            m_ready <= 1'b1;
            repeat (run) @(posedge aclk);
            gap = calm ? 0 : pick_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    // leave cfg_valid high; the caller drops it after the last write
    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // s_valid stays high after the beat unless a gap follows
    task automatic send(mode_t m, id_t d, id_t s, logic [1:0] ct, logic [3:0] dt,
                        logic [7:0] msg, logic pr, logic ts, logic [7:0] rep);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_mode           <= m;
        s_dst_id         <= d;
        s_src_id         <= s;
        s_call_type      <= ct;
        s_data_type      <= dt;
        s_msg_handle     <= msg;
        s_msg_present    <= pr;
        s_timeslot       <= ts;
        s_repeater_index <= rep;
        do @(posedge aclk); while (!s_ready);
    endtask

    // drop valid, wait for every owed beat, then let the block go quiet
    task automatic settle();
        s_valid <= 1'b0;
        do @(negedge aclk); while (results_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic send_random();
        int         r;
        id_t        a;
        id_t        b;
        logic [1:0] ct;
        logic [3:0] dt;
        r  = $urandom_range(0, 99);
        a  = id_pool[$urandom_range(0, POOL_N - 1)];
        b  = id_pool[$urandom_range(0, POOL_N - 1)];
        ct = ct_pool[$urandom_range(0, 1)];
        dt = dt_pool[$urandom_range(0, 1)];
        if (r < 10) begin
            send(mode_t'($urandom_range(0, 3)), id_t'($urandom), id_t'($urandom),
                 2'($urandom), 4'($urandom), 8'($urandom), 1'($urandom),
                 1'($urandom), 8'($urandom));
        end else if (r < 55) begin
            send(MODE_ADD, a, b, ct, dt, 8'($urandom), ($urandom_range(0, 19) != 0),
                 1'($urandom), 8'($urandom));
        end else if (r < 75) begin
            // ack travels the other way
            send(MODE_ACK, b, a, ct, dt, 8'($urandom), 1'($urandom),
                 1'($urandom), 8'($urandom));
        end else if (r < 97) begin
            send(MODE_CALL_END, $urandom_range(0, 1) ? a : b, $urandom_range(0, 1) ? a : b,
                 ct, 4'($urandom), 8'($urandom), 1'($urandom), 1'($urandom), 8'($urandom));
        end else begin
            send(MODE_CLEAR, id_t'($urandom), id_t'($urandom), 2'($urandom), 4'($urandom),
                 8'($urandom), 1'($urandom), 1'($urandom), 8'($urandom));
        end
    endtask

    // fill the table past full with one call in both directions, ack half,
    // then end the call so every entry leaves in one burst
    task automatic fill_and_flush();
        id_t        a;
        id_t        b;
        logic [1:0] ct;
        int         k;
        a  = id_pool[0];
        b  = id_pool[1];
        ct = 2'($urandom);
        send(MODE_CLEAR, id_t'($urandom), id_t'($urandom), 2'($urandom), 4'($urandom),
             8'($urandom), 1'($urandom), 1'($urandom), 8'($urandom));
        for (k = 0; k <= TABLE_DEPTH; k++) begin
            if (k % 2 == 0) begin
                send(MODE_ADD, a, b, ct, unknown_code ^ 4'h5, 8'($urandom), 1'b1,
                     1'($urandom), 8'($urandom));
            end else begin
                send(MODE_ADD, b, a, ct, unknown_code ^ 4'h3, 8'($urandom), 1'b1,
                     1'($urandom), 8'($urandom));
            end
        end
        send(MODE_ACK, b, a, ct, unknown_code ^ 4'h5, 8'($urandom), 1'($urandom),
             1'($urandom), 8'($urandom));
        send(MODE_ACK, b, a, ct, unknown_code ^ 4'h5, 8'($urandom), 1'($urandom),
             1'($urandom), 8'($urandom));
        send(MODE_CALL_END, a, b, ct, 4'($urandom), 8'($urandom), 1'($urandom),
             1'($urandom), 8'($urandom));
    endtask

    initial begin
        int p;
        int k;
        aresetn          <= 1'b0;
        cfg_valid        <= 1'b0;
        cfg_index        <= '0;
        cfg_data         <= '0;
        s_valid          <= 1'b0;
        s_mode           <= '0;
        s_dst_id         <= '0;
        s_src_id         <= '0;
        s_call_type      <= '0;
        s_data_type      <= '0;
        s_msg_handle     <= '0;
        s_msg_present    <= 1'b0;
        s_timeslot       <= 1'b0;
        s_repeater_index <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        own_id       = OWN_ID_DIRECTED;
        unknown_code = 4'hF;
        write_reg(REG_DEFAULT_ID, own_id);
        write_reg(REG_UNKNOWN_DT, 24'h00000F);
        // out-of-range index must not land on the own id
        write_reg(cfg_idx_t'(2), 24'hFFFFFF);
        cfg_valid <= 1'b0;

        send(MODE_ADD, 24'h000001, 24'hFFFFFF, 2'd3, 4'h0, 8'hFF, 1'b1, 1'b1, 8'hFF);
        send(MODE_ADD, 24'h000005, 24'h000006, 2'd0, 4'h2, 8'h11, 1'b0, 1'b0, 8'h00);
        send(MODE_ADD, 24'h000005, 24'h000006, 2'd0, 4'hF, 8'h11, 1'b1, 1'b0, 8'h00);
        send(MODE_ADD, 24'h000000, 24'h000006, 2'd0, 4'h2, 8'h11, 1'b1, 1'b0, 8'h00);
        send(MODE_ADD, 24'h000005, 24'h000000, 2'd0, 4'h2, 8'h11, 1'b1, 1'b0, 8'h00);
        send(MODE_ADD, OWN_ID_DIRECTED, 24'h000002, 2'd1, 4'h5, 8'h00, 1'b1, 1'b0, 8'h00);
        send(MODE_ADD, 24'h000003, 24'h000004, 2'd2, 4'h7, 8'h55, 1'b1, 1'b0, 8'h00);
        send(MODE_ACK, 24'hFFFFFF, 24'h000001, 2'd3, 4'h0, 8'h00, 1'b0, 1'b0, 8'h00);
        send(MODE_ACK, 24'hFFFFFF, 24'h000001, 2'd3, 4'h0, 8'h00, 1'b0, 1'b0, 8'h00);
        send(MODE_ACK, 24'h000004, 24'h000003, 2'd2, 4'h6, 8'h00, 1'b0, 1'b0, 8'h00);
        send(MODE_ADD, 24'h000003, 24'h000004, 2'd2, 4'h7, 8'hAA, 1'b1, 1'b0, 8'h00);
        send(MODE_ACK, 24'h000004, 24'h000003, 2'd2, 4'h7, 8'h00, 1'b0, 1'b0, 8'h00);
        send(MODE_CALL_END, 24'h000001, 24'hFFFFFF, 2'd3, 4'h0, 8'h00, 1'b0, 1'b1, 8'h80);
        send(MODE_CALL_END, 24'h000002, OWN_ID_DIRECTED, 2'd1, 4'h0, 8'h00, 1'b0, 1'b0, 8'h7F);
        send(MODE_CALL_END, 24'h000003, 24'h000004, 2'd0, 4'h0, 8'h00, 1'b0, 1'b0, 8'h01);
        send(MODE_ADD, 24'h000003, 24'h000004, 2'd0, 4'h1, 8'h01, 1'b1, 1'b0, 8'h00);
        send(MODE_CALL_END, 24'h000004, 24'h000003, 2'd2, 4'hF, 8'hFF, 1'b1, 1'b0, 8'h00);
        send(MODE_CALL_END, 24'h000003, 24'h000004, 2'd0, 4'h0, 8'h00, 1'b0, 1'b1, 8'hFF);
        send(MODE_ADD, 24'h000009, 24'h000008, 2'd0, 4'h2, 8'h01, 1'b1, 1'b0, 8'h00);
        send(MODE_CLEAR, 24'hFFFFFF, 24'hFFFFFF, 2'd3, 4'hF, 8'hFF, 1'b1, 1'b1, 8'hFF);
        send(MODE_CALL_END, 24'h000009, 24'h000008, 2'd0, 4'h2, 8'h00, 1'b0, 1'b0, 8'h00);

        for (p = 0; p < N_PHASES; p++) begin
            settle();
            calm = (p % 4 == 3);
            for (k = 0; k < POOL_N; k++) begin
                id_pool[k] = (k == POOL_N - 1 && p % 2 == 1) ? 24'hFFFFFF
                                                             : id_t'($urandom_range(1, 24'hFFFFFF));
            end
            case (p % 4)
                0:       own_id = '0;
                1:       own_id = 24'hFFFFFF;
                2:       own_id = id_pool[0];
                default: own_id = id_t'($urandom);
            endcase
            case (p % 3)
                0:       unknown_code = 4'h0;
                1:       unknown_code = 4'hF;
                default: unknown_code = 4'($urandom);
            endcase
            ct_pool[0] = 2'($urandom);
            ct_pool[1] = 2'($urandom);
            dt_pool[0] = 4'($urandom);
            dt_pool[1] = (p % 3 == 2) ? unknown_code : 4'($urandom);
            write_reg(REG_DEFAULT_ID, own_id);
            write_reg(REG_UNKNOWN_DT, {20'($urandom), unknown_code});
            if (p % 5 == 4) write_reg(cfg_idx_t'($urandom_range(2, 15)), 24'($urandom));
            cfg_valid <= 1'b0;

            if (p == 0 || p == 6) fill_and_flush();
            repeat (ITEMS_PER_PHASE) send_random();
        end
        settle();

        $display("Ran %0d commands across %0d register settings, checked %0d result beats.",
                 commands_seen, N_PHASES + 1, beats_seen);
        $display("Call ends removed %0d entries; %0d adds hit a full table.",
                 entries_removed, full_hits);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
